// ===== hdl/krt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_pkg
// Shared types and constants for the keyed record table.
// ----------------------------------------------------------------------------
package krt_pkg;

   localparam int ENTRIES    = 128;
   localparam int VALUE_BITS = 64;
   localparam int KEY_BITS   = 32;
   localparam int DATA_BITS  = 64;
   localparam int SLOT_BITS  = 7;
   localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_DELETE = 2'd1;
   localparam logic [1:0] MODE_UPDATE = 2'd2;
   localparam logic [1:0] MODE_SEARCH = 2'd3;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_MISSING = 2'd2;

   typedef struct packed {
      logic [1:0]                 mode;
      logic signed [KEY_BITS-1:0] key;
      logic [DATA_BITS-1:0]       value;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [SLOT_BITS-1:0] slot;
      logic [DATA_BITS-1:0] found_value;
   } rsp_type;

   // commit of one entry at the end of a scan
   typedef struct packed {
      logic                  en;
      logic                  set_valid;
      logic                  clr_valid;
      logic                  wr_key;
      logic                  wr_value;
      logic [IDX_W-1:0]      idx;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } wr_type;

endpackage

// ===== hdl/keyed_record_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_record_table
// Key/value table with valid flags; insert, delete, update and search by a
// linear scan of the entry memory, lowest index first.
// ----------------------------------------------------------------------------
// Throughput: one request at a time, set by the single memory read port that
// the scan steps through one entry per cycle; a new request is accepted once
// the previous result has moved into the response register.
// Reset clears all valid flags at once; key and value memories are not cleared.
module keyed_record_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  krt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output krt_pkg::rsp_type rsp_data
);
   import krt_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_HOLD
   } state_type;

   state_type        state_ff;
   req_type          req_ff;
   rsp_type          res_ff;
   rsp_type          rsp_ff;
   logic             rsp_valid_ff;
   logic [IDX_W-1:0] issue_idx_ff;
   logic [IDX_W-1:0] cmp_idx_ff;
   logic             cmp_vld_ff;

   logic                  rd_valid;
   logic [KEY_BITS-1:0]   rd_key;
   logic [VALUE_BITS-1:0] rd_value;
   logic [VALUE_BITS-1:0] new_value;
   logic                  is_insert;
   logic                  hit;
   logic                  finish;
   rsp_type               res_in;
   wr_type                wr;

   assign is_insert = (req_ff.mode == MODE_INSERT);
   assign new_value = req_ff.value[VALUE_BITS-1:0];

   assign hit    = cmp_vld_ff && (is_insert ? !rd_valid
                                             : (rd_valid && rd_key == req_ff.key));
   assign finish = (state_ff == S_SCAN) && cmp_vld_ff && (hit || cmp_idx_ff == IDX_LAST);

   always_comb begin
      res_in           = '0;
      wr               = '0;
      wr.idx           = cmp_idx_ff;
      wr.key           = req_ff.key;
      wr.value         = new_value;
      if (!hit) begin
         res_in.status = is_insert ? ST_FULL : ST_MISSING;
      end else begin
         res_in.status = ST_DONE;
         res_in.slot   = SLOT_BITS'(cmp_idx_ff);
         wr.en         = finish;
         case (req_ff.mode)
            MODE_INSERT: begin
               wr.set_valid = 1'b1;
               wr.wr_key    = 1'b1;
               wr.wr_value  = 1'b1;
            end
            MODE_DELETE: begin
               wr.clr_valid       = 1'b1;
               res_in.found_value = DATA_BITS'(rd_value);
            end
            MODE_UPDATE: begin
               wr.wr_value        = 1'b1;
               res_in.found_value = DATA_BITS'(new_value);
            end
            MODE_SEARCH: begin
               res_in.found_value = DATA_BITS'(rd_value);
            end
            default: begin
               wr.en = 1'b0;
            end
         endcase
      end
   end

   krt_store u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (issue_idx_ff),
      .rd_valid (rd_valid),
      .rd_key   (rd_key),
      .rd_value (rd_value),
      .wr       (wr)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         issue_idx_ff <= '0;
      end else begin
         if (state_ff == S_HOLD && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_ff       <= req_data;
                  issue_idx_ff <= '0;
                  cmp_vld_ff   <= 1'b0;
                  state_ff     <= S_SCAN;
               end
            end
            S_SCAN: begin
               // read issued this cycle is compared the next
               cmp_vld_ff <= 1'b1;
               cmp_idx_ff <= issue_idx_ff;
               if (issue_idx_ff != IDX_LAST) begin
                  issue_idx_ff <= issue_idx_ff + 1'b1;
               end
               if (finish) begin
                  res_ff     <= res_in;
                  cmp_vld_ff <= 1'b0;
                  state_ff   <= S_HOLD;
               end
            end
            S_HOLD: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff       <= res_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_hold_blocked: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HOLD && rsp_valid_ff && !rsp_ready) |=> state_ff == S_HOLD)
      else $error("result left hold while response register busy");

   a_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (state_ff == S_SCAN && hit))
      else $error("entry write outside a scan hit");

   a_write_one_kind: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> !(wr.set_valid && wr.clr_valid))
      else $error("entry both set and cleared");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != ST_DONE) |->
         (rsp_ff.slot == '0 && rsp_ff.found_value == '0))
      else $error("failed request carries nonzero slot or value");

   a_scan_entry: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == S_SCAN) |-> (issue_idx_ff == '0 && !cmp_vld_ff))
      else $error("scan did not start at entry zero");

endmodule

// ===== hdl/krt_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_store
// Entry storage: valid flags in flops, key and value words in synchronous
// memories with one read port and one write port; reads are registered.
// ----------------------------------------------------------------------------
module krt_store (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [krt_pkg::IDX_W-1:0]     rd_idx,
   output logic                          rd_valid,
   output logic [krt_pkg::KEY_BITS-1:0]  rd_key,
   output logic [krt_pkg::VALUE_BITS-1:0] rd_value,
   input  krt_pkg::wr_type               wr
);
   import krt_pkg::*;

   logic [ENTRIES-1:0]    valid_ff;
   logic [KEY_BITS-1:0]   key_mem [ENTRIES];
   logic [VALUE_BITS-1:0] value_mem [ENTRIES];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_valid <= 1'b0;
      end else begin
         rd_valid <= valid_ff[rd_idx];
         if (wr.en && wr.set_valid) begin
            valid_ff[wr.idx] <= 1'b1;
         end else if (wr.en && wr.clr_valid) begin
            valid_ff[wr.idx] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_key <= key_mem[rd_idx];
      if (wr.en && wr.wr_key) begin
         key_mem[wr.idx] <= wr.key;
      end
   end

   always_ff @(posedge clock) begin
      rd_value <= value_mem[rd_idx];
      if (wr.en && wr.wr_value) begin
         value_mem[wr.idx] <= wr.value;
      end
   end

endmodule
